/* hdl/prgc_pkg.sv */
// Shared types and codes for the pump run guard controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package prgc_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_ACTIVE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_RUN          = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF          = 2'd3;

    // Command codes.
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // Stop reason codes.
    localparam logic [2:0] REASON_NONE    = 3'd0;
    localparam logic [2:0] REASON_MANUAL  = 3'd1;
    localparam logic [2:0] REASON_TARGET  = 3'd2;
    localparam logic [2:0] REASON_TIMEOUT = 3'd3;
    localparam logic [2:0] REASON_DRY     = 3'd4;

    localparam logic [15:0] DRY_COUNT_MAX = 16'hFFFF;

    // Reset values of the configuration registers.
    localparam logic [31:0] MAX_RUN_LIMIT_RST = 32'd300000;
    localparam logic [31:0] DRY_RUN_RST       = 32'd10000;
    localparam logic [31:0] MIN_OFF_RST       = 32'd60000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] run_limit_request;
        logic [31:0] target_volume;
        logic [31:0] current_volume;
        logic [2:0]  stop_reason;
        logic        flow_pulse;
    } t_item;

    typedef struct packed {
        logic        relay_level;
        logic        pump_running;
        logic        event_flag;
        logic [2:0]  stop_code;
        logic [31:0] remaining_ms;
        logic [31:0] session_volume;
        logic        in_cooldown;
        logic [31:0] accum_run_ms;
        logic [15:0] dry_run_events;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_cfg_write;

    typedef struct packed {
        logic        relay_active_low;
        logic [31:0] max_run_limit_ms;
        logic [31:0] dry_run_ms;
        logic [31:0] min_off_ms;
    } t_cfg;

endpackage

`default_nettype wire

/* hdl/prgc_stream_if.sv */
// Valid/ready channel interface used for items, results and config writes.
// The payload type is given at instantiation, normally from prgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface prgc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/prgc_cfg_regs.sv */
// Configuration register file of the pump run guard controller.
// Depends on prgc_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps
`default_nettype none

module prgc_cfg_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_valid,
    input  wire prgc_pkg::t_cfg_write i_wr,
    output logic                     o_wr_ready,
    output prgc_pkg::t_cfg           o_cfg
);
    import prgc_pkg::*;

    t_cfg r_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.relay_active_low <= 1'b0;
            r_cfg.max_run_limit_ms <= MAX_RUN_LIMIT_RST;
            r_cfg.dry_run_ms       <= DRY_RUN_RST;
            r_cfg.min_off_ms       <= MIN_OFF_RST;
        end else if (i_wr_valid) begin
            case (i_wr.index)
                CFG_RELAY_ACTIVE_LOW: r_cfg.relay_active_low <= i_wr.data[0];
                CFG_MAX_RUN_LIMIT:    r_cfg.max_run_limit_ms <= i_wr.data;
                CFG_DRY_RUN:          r_cfg.dry_run_ms       <= i_wr.data;
                CFG_MIN_OFF:          r_cfg.min_off_ms       <= i_wr.data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/prgc_in_stage.sv */
// Input register of the pump run guard controller: holds one item for the core.
// Depends on prgc_pkg for the t_item struct.
`timescale 1ns / 1ps
`default_nettype none

module prgc_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire prgc_pkg::t_item i_item,
    output logic                 o_ready,
    input  wire logic            i_take,
    output logic                 o_valid,
    output prgc_pkg::t_item      o_item
);
    import prgc_pkg::*;

    logic  r_valid;
    t_item r_item;

    // A new item may enter while the held one is being taken by the core.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/prgc_core.sv */
// Session state, per-tick decision logic and result register of the controller.
// Depends on prgc_pkg for item, result and configuration types and codes.
`timescale 1ns / 1ps
`default_nettype none

module prgc_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire prgc_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    input  wire prgc_pkg::t_item i_item,
    output logic                 o_take,
    output logic                 o_res_valid,
    output prgc_pkg::t_result    o_res,
    input  wire logic            i_res_ready
);
    import prgc_pkg::*;

    logic [31:0] r_now, n_now;
    logic        r_running, n_running;
    logic [31:0] r_start, n_start;
    logic [31:0] r_stop, n_stop;
    logic [31:0] r_pulse, n_pulse;
    logic        r_stopped, n_stopped;
    logic [31:0] r_target, n_target;
    logic [31:0] r_start_vol, n_start_vol;
    logic [2:0]  r_reason, n_reason;
    logic [31:0] r_total, n_total;
    logic [15:0] r_dry, n_dry;
    logic        r_lim_act, n_lim_act;
    logic [31:0] r_lim_dur, n_lim_dur;

    logic        r_out_valid;
    t_result     r_res, n_res;

    logic        advance;
    logic [31:0] elapsed;
    logic        cooling_pre;
    logic [31:0] vol_delta;
    logic [31:0] run_req;
    logic        halt;
    logic [2:0]  halt_reason;
    logic        evt;
    logic [31:0] elapsed_post;
    logic [31:0] remain;

    assign advance     = !r_out_valid || i_res_ready;
    assign o_take      = i_valid && advance;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    assign elapsed     = r_now - r_start;
    assign cooling_pre = r_stopped && !r_running && ((r_now - r_stop) < i_cfg.min_off_ms);
    assign vol_delta   = (i_item.current_volume > r_start_vol) ?
                         (i_item.current_volume - r_start_vol) : 32'd0;
    assign run_req     = (i_item.run_limit_request == 32'd0 ||
                          i_item.run_limit_request > i_cfg.max_run_limit_ms) ?
                         i_cfg.max_run_limit_ms : i_item.run_limit_request;

    always_comb begin
        n_now       = r_now + 32'd1;
        n_running   = r_running;
        n_start     = r_start;
        n_stop      = r_stop;
        n_pulse     = r_pulse;
        n_stopped   = r_stopped;
        n_target    = r_target;
        n_start_vol = r_start_vol;
        n_reason    = r_reason;
        n_total     = r_total;
        n_dry       = r_dry;
        n_lim_act   = r_lim_act;
        n_lim_dur   = r_lim_dur;
        halt        = 1'b0;
        halt_reason = REASON_NONE;
        evt         = 1'b0;

        case (i_item.cmd)
            CMD_UPDATE: begin
                if (r_running) begin
                    // Timeout wins over dry run, which wins over the target stop.
                    if (r_lim_act && elapsed >= r_lim_dur) begin
                        halt        = 1'b1;
                        halt_reason = REASON_TIMEOUT;
                        evt         = 1'b1;
                    end else begin
                        if (i_item.flow_pulse) begin
                            n_pulse = r_now;
                        end
                        if (elapsed > i_cfg.dry_run_ms &&
                            (r_now - n_pulse) > i_cfg.dry_run_ms) begin
                            if (r_dry != DRY_COUNT_MAX) begin
                                n_dry = r_dry + 16'd1;
                            end
                            halt        = 1'b1;
                            halt_reason = REASON_DRY;
                            evt         = 1'b1;
                        end else if (r_target != 32'd0 && vol_delta >= r_target) begin
                            halt        = 1'b1;
                            halt_reason = REASON_TARGET;
                            evt         = 1'b1;
                        end
                    end
                end
            end
            CMD_START: begin
                if (!r_running && !cooling_pre) begin
                    n_running   = 1'b1;
                    n_start     = r_now;
                    n_pulse     = r_now;
                    n_target    = i_item.target_volume;
                    n_start_vol = i_item.current_volume;
                    n_reason    = REASON_NONE;
                    n_lim_act   = 1'b1;
                    n_lim_dur   = run_req;
                    evt         = 1'b1;
                end
            end
            CMD_STOP: begin
                halt        = 1'b1;
                halt_reason = (i_item.stop_reason > REASON_DRY) ? REASON_MANUAL
                                                                : i_item.stop_reason;
            end
            default: begin
            end
        endcase

        if (halt) begin
            if (r_running) begin
                n_total = r_total + elapsed;
            end
            n_running = 1'b0;
            n_stop    = r_now;
            n_stopped = 1'b1;
            n_reason  = halt_reason;
            n_lim_act = 1'b0;
        end
    end

    // The result reflects the state after this tick's command.
    assign elapsed_post = r_now - n_start;
    assign remain = (n_running && n_lim_act && elapsed_post < n_lim_dur) ?
                    (n_lim_dur - elapsed_post) : 32'd0;

    always_comb begin
        n_res.relay_level      = n_running ^ i_cfg.relay_active_low;
        n_res.pump_running     = n_running;
        n_res.event_flag       = evt;
        n_res.stop_code        = n_reason;
        n_res.remaining_ms     = remain;
        n_res.session_volume   = (i_item.current_volume > n_start_vol) ?
                                 (i_item.current_volume - n_start_vol) : 32'd0;
        n_res.in_cooldown      = n_stopped && !n_running &&
                                 ((r_now - n_stop) < i_cfg.min_off_ms);
        n_res.accum_run_ms     = n_total;
        n_res.dry_run_events   = n_dry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= 32'd0;
            r_running   <= 1'b0;
            r_start     <= 32'd0;
            r_stop      <= 32'd0;
            r_pulse     <= 32'd0;
            r_stopped   <= 1'b0;
            r_target    <= 32'd0;
            r_start_vol <= 32'd0;
            r_reason    <= REASON_NONE;
            r_total     <= 32'd0;
            r_dry       <= 16'd0;
            r_lim_act   <= 1'b0;
            r_lim_dur   <= 32'd0;
        end else if (o_take) begin
            r_now       <= n_now;
            r_running   <= n_running;
            r_start     <= n_start;
            r_stop      <= n_stop;
            r_pulse     <= n_pulse;
            r_stopped   <= n_stopped;
            r_target    <= n_target;
            r_start_vol <= n_start_vol;
            r_reason    <= n_reason;
            r_total     <= n_total;
            r_dry       <= n_dry;
            r_lim_act   <= n_lim_act;
            r_lim_dur   <= n_lim_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    a_no_cooldown_while_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.pump_running && r_res.in_cooldown))
        else $error("result reports cooldown while the pump runs");

    a_dry_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_dry >= $past(r_dry)))
        else $error("dry run count decreased");

    a_start_flags_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_running)) |-> (r_out_valid && r_res.event_flag))
        else $error("session started without an event in its result");

    a_clock_per_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_take)) |-> (r_now == $past(r_now) + 32'd1))
        else $error("millisecond clock did not advance by one per item");

endmodule

`default_nettype wire

/* hdl/pump_run_guard_controller.sv */
// Pump run guard controller: one millisecond tick per item, gated start, auto stops.
// Depends on prgc_pkg, prgc_stream_if, prgc_cfg_regs, prgc_in_stage and prgc_core.
//
// Each input item is one millisecond tick carrying an update, start or stop
// command with the flow meter reading. The block accepts one item per clock
// cycle while the result side takes results; a stalled result holds the flow.
// An accepted item passes the input register, then the decision logic into
// the result register. The rate is set by the session state update, which is
// registered once per item so each tick sees the state left by the one before.
// The result register and the input register let a new item enter while a
// result waits. Configuration writes are always accepted and take effect on
// the next cycle; write them only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module pump_run_guard_controller (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    prgc_stream_if.sink   i_item,
    prgc_stream_if.source o_result,
    prgc_stream_if.sink   i_cfg
);
    import prgc_pkg::*;

    t_cfg    w_cfg;
    logic    w_take;
    logic    w_core_valid;
    t_item   w_core_item;
    t_result w_res;

    prgc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr       (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (w_cfg)
    );

    prgc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_item  (i_item.data),
        .o_ready (i_item.ready),
        .i_take  (w_take),
        .o_valid (w_core_valid),
        .o_item  (w_core_item)
    );

    prgc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_core_valid),
        .i_item      (w_core_item),
        .o_take      (w_take),
        .o_res_valid (o_result.valid),
        .o_res       (w_res),
        .i_res_ready (o_result.ready)
    );

    assign o_result.data = w_res;

endmodule

`default_nettype wire

/* tb/prgc_tick_checker.sv */
// Predicts and checks the results of the pump run guard controller.
// Depends on prgc_pkg and prgc_stream_if. It watches the item, result and config channels.
`timescale 1ns / 1ps

module prgc_tick_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    prgc_stream_if i_item,
    prgc_stream_if o_result,
    prgc_stream_if i_cfg,
    output int     o_errors,
    output int     o_pending
);
    import prgc_pkg::*;

    t_cfg        cfg_q;
    logic [31:0] now_ms;
    logic        running;
    logic [31:0] sess_start_ms;
    logic [31:0] sess_stop_ms;
    logic [31:0] pulse_ms;
    logic        stopped_once;
    logic [31:0] target_ml;
    logic [31:0] base_ml;
    logic [2:0]  reason;
    logic [31:0] run_total_ms;
    logic [15:0] dry_stops;
    logic        limit_on;
    logic [31:0] limit_ms;

    t_result     tick_results_q[$];
    int          err_cnt = 0;

    assign o_errors = err_cnt;

    function automatic logic cooling_now();
        return stopped_once && !running && ((now_ms - sess_stop_ms) < cfg_q.min_off_ms);
    endfunction

    function automatic logic [31:0] volume_gain(input logic [31:0] cur);
        return (cur > base_ml) ? cur - base_ml : 32'd0;
    endfunction

    function automatic void halt_session(input logic [2:0] why);
        if (running) begin
            run_total_ms = run_total_ms + (now_ms - sess_start_ms);
        end
        running      = 1'b0;
        sess_stop_ms = now_ms;
        stopped_once = 1'b1;
        reason       = why;
        limit_on     = 1'b0;
    endfunction

    // Applies one millisecond tick to the state and returns the result it produces.
    function automatic t_result predict_tick(input t_item it);
        t_result     r;
        logic [31:0] span;
        logic [31:0] lim;
        logic        fired;
        fired = 1'b0;
        case (it.cmd)
            CMD_UPDATE: begin
                if (running) begin
                    span = now_ms - sess_start_ms;
                    if (limit_on && span >= limit_ms) begin
                        halt_session(REASON_TIMEOUT);
                        fired = 1'b1;
                    end else begin
                        if (it.flow_pulse) begin
                            pulse_ms = now_ms;
                        end
                        if (span > cfg_q.dry_run_ms &&
                            (now_ms - pulse_ms) > cfg_q.dry_run_ms) begin
                            if (dry_stops != DRY_COUNT_MAX) begin
                                dry_stops = dry_stops + 16'd1;
                            end
                            halt_session(REASON_DRY);
                            fired = 1'b1;
                        end else if (target_ml != 32'd0 &&
                                     volume_gain(it.current_volume) >= target_ml) begin
                            halt_session(REASON_TARGET);
                            fired = 1'b1;
                        end
                    end
                end
            end
            CMD_START: begin
                if (!running && !cooling_now()) begin
                    lim = it.run_limit_request;
                    if (lim == 32'd0 || lim > cfg_q.max_run_limit_ms) begin
                        lim = cfg_q.max_run_limit_ms;
                    end
                    running       = 1'b1;
                    sess_start_ms = now_ms;
                    pulse_ms      = now_ms;
                    target_ml     = it.target_volume;
                    base_ml       = it.current_volume;
                    reason        = REASON_NONE;
                    limit_on      = 1'b1;
                    limit_ms      = lim;
                    fired         = 1'b1;
                end
            end
            CMD_STOP: begin
                halt_session((it.stop_reason > REASON_DRY) ? REASON_MANUAL : it.stop_reason);
            end
            default: begin
            end
        endcase

        r.remaining_ms = 32'd0;
        if (running && limit_on) begin
            span = now_ms - sess_start_ms;
            r.remaining_ms = (span < limit_ms) ? limit_ms - span : 32'd0;
        end
        r.relay_level      = running ^ cfg_q.relay_active_low;
        r.pump_running     = running;
        r.event_flag       = fired;
        r.stop_code        = reason;
        r.session_volume   = volume_gain(it.current_volume);
        r.in_cooldown      = cooling_now();
        r.accum_run_ms     = run_total_ms;
        r.dry_run_events   = dry_stops;
        now_ms = now_ms + 32'd1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        t_cfg_write wr;
        if (!i_rst_n) begin
            cfg_q.relay_active_low = 1'b0;
            cfg_q.max_run_limit_ms = MAX_RUN_LIMIT_RST;
            cfg_q.dry_run_ms       = DRY_RUN_RST;
            cfg_q.min_off_ms       = MIN_OFF_RST;
            now_ms        = '0;
            running       = 1'b0;
            sess_start_ms = '0;
            sess_stop_ms  = '0;
            pulse_ms      = '0;
            stopped_once  = 1'b0;
            target_ml     = '0;
            base_ml       = '0;
            reason        = REASON_NONE;
            run_total_ms  = '0;
            dry_stops     = '0;
            limit_on      = 1'b0;
            limit_ms      = '0;
            tick_results_q.delete();
        end else begin
            if (o_result.valid && o_result.ready) begin
                got = o_result.data;
                if (tick_results_q.size() == 0) begin
                    $error("result item arrived with no tick outstanding");
                    err_cnt++;
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("relay_level", 32'(want.relay_level), 32'(got.relay_level));
                    check_field("pump_running", 32'(want.pump_running),
                                32'(got.pump_running));
                    check_field("event_flag", 32'(want.event_flag), 32'(got.event_flag));
                    check_field("stop_code", 32'(want.stop_code), 32'(got.stop_code));
                    check_field("remaining_ms", want.remaining_ms, got.remaining_ms);
                    check_field("session_volume", want.session_volume, got.session_volume);
                    check_field("in_cooldown", 32'(want.in_cooldown), 32'(got.in_cooldown));
                    check_field("accum_run_ms", want.accum_run_ms, got.accum_run_ms);
                    check_field("dry_run_events", 32'(want.dry_run_events),
                                32'(got.dry_run_events));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                wr = i_cfg.data;
                case (wr.index)
                    CFG_RELAY_ACTIVE_LOW: cfg_q.relay_active_low = wr.data[0];
                    CFG_MAX_RUN_LIMIT:    cfg_q.max_run_limit_ms = wr.data;
                    CFG_DRY_RUN:          cfg_q.dry_run_ms       = wr.data;
                    CFG_MIN_OFF:          cfg_q.min_off_ms       = wr.data;
                    default: begin
                    end
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                tick_results_q.push_back(predict_tick(i_item.data));
            end
        end
        o_pending <= tick_results_q.size();
    end

endmodule

/* tb/tb.sv */
// Top of the pump run guard controller testbench: clock, reset, stimulus and verdict.
// Depends on prgc_pkg, prgc_stream_if, the controller RTL and prgc_tick_checker.
`timescale 1ns / 1ps

module tb;
    import prgc_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    logic        clk;
    logic        rst_n;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          idle_on;
    logic [31:0] meter_ml;

    prgc_stream_if #(.T(t_item))      item_if ();
    prgc_stream_if #(.T(t_result))    result_if ();
    prgc_stream_if #(.T(t_cfg_write)) cfg_if ();

    pump_run_guard_controller u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    prgc_tick_checker u_tick_chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_item    (item_if),
        .o_result  (result_if),
        .i_cfg     (cfg_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: ready drops for random bursts while idling is enabled.
    initial begin
        int stall;
        stall = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                result_if.ready = 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 12) - 1;
                result_if.ready = 1'b0;
            end else begin
                result_if.ready = 1'b1;
            end
        end
    end

    function automatic t_item make_tick(input logic [1:0] cmd, input logic [31:0] req,
                                        input logic [31:0] tgt, input logic [31:0] cur,
                                        input logic [2:0] why, input logic pulse);
        t_item it;
        it.cmd               = cmd;
        it.run_limit_request = req;
        it.target_volume     = tgt;
        it.current_volume    = cur;
        it.stop_reason       = why;
        it.flow_pulse        = pulse;
        return it;
    endfunction

    // Valid stays high from one item to the next unless an idle burst is inserted.
    task automatic send_tick(input t_item it);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            item_if.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        item_if.valid = 1'b1;
        item_if.data  = it;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        item_if.valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        t_cfg_write wr;
        wr.index = idx;
        wr.data  = val;
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = wr;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_config(input logic relay_low, input logic [31:0] max_ms,
                              input logic [31:0] dry_ms, input logic [31:0] off_ms);
        drain_results();
        write_reg(CFG_RELAY_ACTIVE_LOW, {31'd0, relay_low});
        write_reg(CFG_MAX_RUN_LIMIT, max_ms);
        write_reg(CFG_DRY_RUN, dry_ms);
        write_reg(CFG_MIN_OFF, off_ms);
    endtask

    initial begin
        t_item it;
        int    sel;
        int    pulse_pct;
        item_if.valid = 1'b0;
        item_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        rst_n         = 1'b0;
        idle_on       = 1'b1;
        meter_ml      = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: idle update, default limit, refused starts, odd codes.
        send_tick(make_tick(CMD_UPDATE, 0, 0, 0, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_START, 0, 0, 50, REASON_NONE, 1'b1));
        send_tick(make_tick(CMD_UPDATE, 0, 0, 60, REASON_NONE, 1'b1));
        send_tick(make_tick(CMD_START, 9, 9, 70, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, 3'd7, 1'b1));
        send_tick(make_tick(CMD_STOP, 0, 0, 80, 3'd7, 1'b0));
        send_tick(make_tick(CMD_START, 10, 0, 80, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_STOP, 0, 0, 80, REASON_NONE, 1'b0));

        // A zero maximum limit times out on the first update after the start.
        set_config(1'b1, 32'd0, ALL_ONES, 32'd0);
        send_tick(make_tick(CMD_START, 5, ALL_ONES, ALL_ONES, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_UPDATE, 0, 0, 0, REASON_NONE, 1'b1));
        send_tick(make_tick(CMD_START, 0, 0, 0, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_STOP, 0, 0, 0, REASON_DRY, 1'b0));

        // Endless cooldown refuses every start.
        set_config(1'b1, ALL_ONES, 32'd0, ALL_ONES);
        send_tick(make_tick(CMD_START, 0, 0, 0, REASON_NONE, 1'b0));

        // Zero dry-run time, then a target stop.
        set_config(1'b1, ALL_ONES, 32'd0, 32'd0);
        send_tick(make_tick(CMD_START, ALL_ONES, 0, 7, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_UPDATE, 0, 0, 7, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_START, 3, 10, 100, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_UPDATE, 0, 0, 105, REASON_NONE, 1'b1));
        send_tick(make_tick(CMD_UPDATE, 0, 0, 110, REASON_NONE, 1'b1));

        // Request above the maximum is clamped; the meter falls below the start volume.
        set_config(1'b0, 32'd3, ALL_ONES, 32'd0);
        send_tick(make_tick(CMD_START, 10, 0, 20, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_UPDATE, 0, 0, 10, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_UPDATE, 0, 0, 25, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_UPDATE, 0, 0, 30, REASON_NONE, 1'b0));
        send_tick(make_tick(CMD_STOP, 0, 0, 30, REASON_TIMEOUT, 1'b0));

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    set_config(1'b0, $urandom_range(1, 40), $urandom_range(0, 15),
                               $urandom_range(0, 25));
                    pulse_pct = 60;
                end
                1: begin
                    set_config(1'b1, $urandom_range(1, 40), $urandom_range(2, 15),
                               $urandom_range(0, 25));
                    pulse_pct = 30;
                end
                2: begin
                    set_config(1'($urandom_range(0, 1)), $urandom_range(1, 40), 32'd0, 32'd0);
                    pulse_pct = 90;
                end
                3: begin
                    set_config(1'b0, 32'd1, ALL_ONES, $urandom_range(0, 5));
                    pulse_pct = 50;
                end
                default: begin
                    set_config(1'($urandom_range(0, 1)), $urandom_range(1, 60),
                               $urandom_range(1, 20), $urandom_range(0, 30));
                    pulse_pct = 70;
                    idle_on = 1'b0;
                end
            endcase
            for (int n = 0; n < 120; n++) begin
                // Hold off mid-phase until every outstanding result is back.
                if (ph == 1 && n == 60) begin
                    drain_results();
                end
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    it.cmd = CMD_UPDATE;
                end else if (sel < 75) begin
                    it.cmd = CMD_START;
                end else if (sel < 93) begin
                    it.cmd = CMD_STOP;
                end else begin
                    it.cmd = CMD_UNUSED;
                end
                it.run_limit_request = ($urandom_range(0, 7) == 0) ? $urandom()
                                                                   : $urandom_range(0, 50);
                if ($urandom_range(0, 9) == 0) begin
                    it.target_volume = $urandom();
                end else if ($urandom_range(0, 3) == 0) begin
                    it.target_volume = 32'd0;
                end else begin
                    it.target_volume = $urandom_range(1, 40);
                end
                // The meter mostly creeps upward, with rare jumps anywhere in range.
                if ($urandom_range(0, 19) == 0) begin
                    meter_ml = $urandom();
                end else begin
                    meter_ml = meter_ml + $urandom_range(0, 3);
                end
                it.current_volume = meter_ml;
                it.stop_reason    = 3'($urandom_range(0, 7));
                it.flow_pulse     = ($urandom_range(0, 99) < pulse_pct);
                send_tick(it);
            end
        end

        drain_results();
        repeat (20) @(negedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
